[sv/slps_pkg.sv]
// Shared types and constants for the steep line pixel stepper.
`timescale 1ns / 1ps

package slps_pkg;

    localparam int COORD_IN_W      = 8;
    localparam int COLOR_W         = 32;
    localparam int DEC_W           = 12;
    localparam int CANVAS_SIZE_DEF = 256;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 32'h0000_00FF;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [COORD_IN_W-1:0] x_start;
        logic [COORD_IN_W-1:0] y_start;
        logic [COORD_IN_W-1:0] x_end;
        logic [COORD_IN_W-1:0] y_end;
    } req_t;

    typedef struct packed {
        logic [COORD_IN_W-1:0] pixel_x;
        logic [COORD_IN_W-1:0] pixel_y;
        logic [COLOR_W-1:0]    pixel_color;
        logic                  last_pixel;
    } pix_t;

endpackage

[sv/steep_line_pixel_stepper.sv]
// Top level of the steep line pixel stepper: handshakes, color register, result register.
`timescale 1ns / 1ps

// Midpoint line stepper for steep lines of positive slope.
// Input channel (in_valid / in_ready): a request with req_type = start latches the
// endpoints (swapped so the column rises) and yields the first pixel; req_type =
// advance moves one row up and yields the next pixel. Advance while no line is
// active yields nothing. The pixel on the end row carries last_pixel.
// Output channel (out_valid / out_ready): pixel_x, pixel_y, pixel_color, last_pixel.
// Config: cfg_we / cfg_wdata write the draw color (reset 0x000000FF); write only idle.
// Path: an accepted request is held in the input register; when it fires, its pixel is
// written into the result register, which drives out_valid.
// Throughput: one request per cycle while the output is not stalled; the decision add and
// compare in the step logic are combinational, so back-to-back advances stream one pixel per clock.
// Stall: with out_ready low the result holds, the input register fills, and
// in_ready drops; nothing is lost or repeated.
// Reset: no line active, both registers empty, state cleared, color to default.
module steep_line_pixel_stepper #(
    parameter int CANVAS_SIZE = slps_pkg::CANVAS_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [slps_pkg::COORD_IN_W-1:0] x_start,
    input  logic [slps_pkg::COORD_IN_W-1:0] y_start,
    input  logic [slps_pkg::COORD_IN_W-1:0] x_end,
    input  logic [slps_pkg::COORD_IN_W-1:0] y_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [slps_pkg::COORD_IN_W-1:0] pixel_x,
    output logic [slps_pkg::COORD_IN_W-1:0] pixel_y,
    output logic [slps_pkg::COLOR_W-1:0]    pixel_color,
    output logic                            last_pixel,
    input  logic                            cfg_we,
    input  logic [slps_pkg::COLOR_W-1:0]    cfg_wdata
);
    import slps_pkg::*;

    logic               in_valid_reg, in_valid_next;
    req_t               in_req_reg;
    logic               out_valid_reg, out_valid_next;
    pix_t               out_pix_reg;
    logic [COLOR_W-1:0] color_reg;

    pix_t step_pix;
    logic step_has_pix;
    logic fire;

    // request in the input register moves when the result slot is free
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_ready ? in_valid : in_valid_reg;
        if (fire)
            out_valid_next = step_has_pix;
        else
            out_valid_next = out_valid_reg && !out_ready;
    end

    slps_core #(
        .CANVAS_SIZE(CANVAS_SIZE)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .req    (in_req_reg),
        .color  (color_reg),
        .pix    (step_pix),
        .has_pix(step_has_pix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            color_reg     <= COLOR_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                color_reg <= cfg_wdata;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_req_reg.req_type <= req_type;
            in_req_reg.x_start  <= x_start;
            in_req_reg.y_start  <= y_start;
            in_req_reg.x_end    <= x_end;
            in_req_reg.y_end    <= y_end;
        end
        if (fire && step_has_pix)
            out_pix_reg <= step_pix;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_pix_reg.pixel_x;
    assign pixel_y     = out_pix_reg.pixel_y;
    assign pixel_color = out_pix_reg.pixel_color;
    assign last_pixel  = out_pix_reg.last_pixel;

endmodule

[sv/slps_core.sv]
// Line state registers and the combinational setup / advance step.
`timescale 1ns / 1ps

module slps_core #(
    parameter int CANVAS_SIZE = slps_pkg::CANVAS_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  slps_pkg::req_t               req,
    input  logic [slps_pkg::COLOR_W-1:0] color,
    output slps_pkg::pix_t               pix,
    output logic                         has_pix
);
    import slps_pkg::*;

    localparam int COORD_W = $clog2(CANVAS_SIZE);
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP = (1 << RECIP_SHIFT) / CANVAS_SIZE;
    localparam int PROD_W = RECIP_SHIFT + COORD_IN_W;

    // Reduce an input coordinate modulo the canvas size: floor reciprocal
    // estimate, then at most one correction.
    function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_IN_W-1:0] v);
        logic [PROD_W-1:0]     prod;
        logic [COORD_IN_W-1:0] q;
        logic [COORD_IN_W:0]   r;
        prod = PROD_W'(v) * PROD_W'(RECIP);
        q = prod[PROD_W-1:RECIP_SHIFT];
        r = {1'b0, v} - (COORD_IN_W + 1)'(int'(q) * CANVAS_SIZE);
        if (int'(r) >= CANVAS_SIZE)
            r = r - (COORD_IN_W + 1)'(CANVAS_SIZE);
        if (CANVAS_SIZE >= (1 << COORD_IN_W))
            return COORD_W'(v);
        else
            return COORD_W'(r);
    endfunction

    function automatic logic [COORD_W-1:0] coord_next(input logic [COORD_W-1:0] v);
        logic [COORD_W:0] n;
        n = {1'b0, v} + (COORD_W + 1)'(1);
        if (int'(n) >= CANVAS_SIZE)
            return '0;
        else
            return n[COORD_W-1:0];
    endfunction

    logic               active_reg, active_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] stop_reg, stop_next;
    logic [DEC_W-1:0]   dec_reg, dec_next;
    logic [DEC_W-1:0]   diag_reg, diag_next;
    logic [DEC_W-1:0]   straight_reg, straight_next;

    logic [COORD_W-1:0] xa, ya, xb, yb;
    logic [DEC_W-1:0]   dx, dy;
    logic               is_start;
    logic               last;

    assign is_start = (req.req_type == REQ_START);

    always_comb
    begin
        xa = wrap_coord(req.x_start);
        ya = wrap_coord(req.y_start);
        xb = wrap_coord(req.x_end);
        yb = wrap_coord(req.y_end);
        if (xb < xa)
        begin
            xa = wrap_coord(req.x_end);
            ya = wrap_coord(req.y_end);
            xb = wrap_coord(req.x_start);
            yb = wrap_coord(req.y_start);
        end
        dx = DEC_W'(xb) - DEC_W'(xa);
        dy = DEC_W'(yb) - DEC_W'(ya);

        active_next   = active_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        stop_next     = stop_reg;
        dec_next      = dec_reg;
        diag_next     = diag_reg;
        straight_next = straight_reg;
        has_pix       = 1'b0;
        last          = 1'b0;

        if (is_start)
        begin
            dec_next      = dy - (dx << 1);
            diag_next     = (dy - dx) << 1;
            straight_next = DEC_W'(0) - (dx << 1);
            col_next      = xa;
            row_next      = ya;
            stop_next     = yb;
            last          = (ya == yb);
            active_next   = !last;
            has_pix       = 1'b1;
        end
        else if (active_reg)
        begin
            // negative decision: take the diagonal step
            if (dec_reg[DEC_W-1])
            begin
                dec_next = dec_reg + diag_reg;
                col_next = coord_next(col_reg);
            end
            else
            begin
                dec_next = dec_reg + straight_reg;
            end
            row_next = coord_next(row_reg);
            last     = (row_next == stop_reg);
            if (last)
                active_next = 1'b0;
            has_pix = 1'b1;
        end

        pix.pixel_x     = COORD_IN_W'(col_next);
        pix.pixel_y     = COORD_IN_W'(row_next);
        pix.pixel_color = color;
        pix.last_pixel  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            stop_reg     <= '0;
            dec_reg      <= '0;
            diag_reg     <= '0;
            straight_reg <= '0;
        end
        else if (fire)
        begin
            active_reg   <= active_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            stop_reg     <= stop_next;
            dec_reg      <= dec_next;
            diag_reg     <= diag_next;
            straight_reg <= straight_next;
        end
    end

endmodule
